>>> design/givens_rotation_matrix_engine_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef GIVENS_ROTATION_MATRIX_ENGINE_MACROS_SVH
`define GIVENS_ROTATION_MATRIX_ENGINE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define GRME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define GRME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/grme_pkg.sv
package grme_pkg;

  localparam int MaxOrderDef    = 8;
  localparam int CordicStepsDef = 16;

  localparam int ElemW  = 16;
  localparam int DotW   = 40;
  localparam int DiffW  = 24;
  localparam int MulW   = 24;
  localparam int ProdW  = 2 * MulW;
  localparam int SumW   = 56;
  localparam int RootW  = SumW / 2;
  localparam int DriftW = 24;
  localparam int ZW     = 34;

  localparam logic signed [ElemW-1:0] OneQ14   = 16'sd16384;
  localparam logic [DriftW-1:0]       DriftMax = {DriftW{1'b1}};

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_ROTATE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_DRIFT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PLANE = 2'd1,
    ST_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic                    done;
    logic signed [ElemW-1:0] cos_v;
    logic signed [ElemW-1:0] sin_v;
  } cordic_res_t;

  // Arctangent of 2^-k, 2^31 meaning pi.
  function automatic logic signed [ZW-1:0] atan_of(input logic [4:0] k);
    logic signed [ZW-1:0] v;
    case (k)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q.28 sum half up to Q1.14 and saturate.
  function automatic logic signed [ElemW-1:0] round_q28(input logic signed [DotW-1:0] p);
    logic signed [DotW-1:0] t;
    t = (p + DotW'(8192)) >>> 14;
    if (t > DotW'(32767)) begin
      return 16'sh7fff;
    end else if (t < -DotW'(32768)) begin
      return 16'sh8000;
    end
    return t[ElemW-1:0];
  endfunction

endpackage

>>> design/grme_req_if.sv
interface grme_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [2:0]  row_index;
  logic [2:0]  column_index;
  logic [15:0] element_value;
  logic [2:0]  plane_first;
  logic [2:0]  plane_second;
  logic [15:0] rotation_angle;
  logic        last_in_batch;

  modport source (output valid, cmd, row_index, column_index, element_value, plane_first,
                  plane_second, rotation_angle, last_in_batch, input ready);
  modport sink (input valid, cmd, row_index, column_index, element_value, plane_first,
                plane_second, rotation_angle, last_in_batch, output ready);
endinterface

>>> design/grme_rsp_if.sv
interface grme_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [23:0] drift_value;
  logic [1:0]  status;
  logic        batch_done;

  modport source (output valid, read_value, drift_value, status, batch_done, input ready);
  modport sink (input valid, read_value, drift_value, status, batch_done, output ready);
endinterface

>>> design/givens_rotation_matrix_engine.sv
// Write and read touch one entry; rotate runs the CORDIC, then updates each row in use;
//   drift sums every product (order cubed), squares each entry (order squared), takes the root.
// Throughput: one request at a time; the next is taken once the result has gone.
// The shared multiplier and the single read port of the matrix memory serialise this work.
// Reset: asynchronous, active low; matrix reads as identity, order returns to 8.
module givens_rotation_matrix_engine import grme_pkg::*; #(
  parameter int MAX_ORDER    = MaxOrderDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  grme_req_if.sink   req,
  grme_rsp_if.source rsp,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);
  localparam int Depth = MAX_ORDER * MAX_ORDER;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(MAX_ORDER + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_RD_REQ, S_RD_DATA, S_ROT_CORDIC, S_ROT_RDA, S_ROT_RDB, S_ROT_P0, S_ROT_P1,
    S_ROT_P2, S_ROT_P3, S_ROT_P4, S_ROT_WB, S_DR_RDI, S_DR_RDJ, S_DR_P0, S_DR_ACC,
    S_DR_RND, S_DR_SQ, S_DR_SUM, S_DR_ROOT_GO, S_DR_ROOT, S_RESP
  } state_e;

  state_e state_q;

  logic [3:0]          order_q;
  logic [IW-1:0]       n;
  logic [Depth-1:0]    vld_q;
  logic [IW-1:0]       r_q, i_q, j_q, k_q;
  logic [2:0]          row_q, col_q, pi_q, pj_q;
  logic signed [15:0]  c_q, s_q, a_q, b_q, mem_val;
  logic signed [DotW-1:0]  acc_q;
  logic signed [DiffW-1:0] d_q;
  logic signed [ProdW-1:0] prod_q;
  logic [SumW-1:0]     sum_q;
  logic                rd_vld_q, rd_diag_q;
  logic signed [MulW-1:0] op_a, op_b;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;
  logic [IW-1:0]       rd_r, rd_c;

  logic                acc_cmd, idx_ok, plane_ok, cordic_go, root_done;
  logic [RootW-1:0]    root;
  cordic_res_t         cres;

  logic [15:0]         out_read_q;
  logic [DriftW-1:0]   out_drift_q;
  status_e             out_status_q;
  logic                out_batch_q;

  function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [4:0] c);
    return AW'(int'(r) * MAX_ORDER + int'(c));
  endfunction

  assign n = IW'((int'(order_q) > MAX_ORDER) ? MAX_ORDER : int'(order_q));

  assign acc_cmd  = req.valid && req.ready;
  assign idx_ok   = (int'(req.row_index) < int'(n)) && (int'(req.column_index) < int'(n));
  assign plane_ok = (int'(req.plane_first) < int'(n)) && (int'(req.plane_second) < int'(n));
  assign cordic_go = acc_cmd && (cmd_e'(req.cmd) == CMD_ROTATE) && plane_ok;

  assign req.ready       = (state_q == S_IDLE);
  assign rsp.valid       = (state_q == S_RESP);
  assign rsp.read_value  = out_read_q;
  assign rsp.drift_value = out_drift_q;
  assign rsp.status      = out_status_q;
  assign rsp.batch_done  = out_batch_q;

  // unwritten entries read as identity
  assign mem_val = rd_vld_q ? ram_rdata : (rd_diag_q ? OneQ14 : 16'sd0);

  always_comb begin
    rd_r = '0;
    rd_c = '0;
    case (state_q)
      S_RD_REQ: begin
        rd_r = IW'(row_q);
        rd_c = IW'(col_q);
      end
      S_ROT_RDA: begin
        rd_r = r_q;
        rd_c = IW'(pi_q);
      end
      S_ROT_RDB: begin
        rd_r = r_q;
        rd_c = IW'(pj_q);
      end
      S_DR_RDI: begin
        rd_r = k_q;
        rd_c = i_q;
      end
      S_DR_RDJ: begin
        rd_r = k_q;
        rd_c = j_q;
      end
      default: ;
    endcase
  end

  assign ram_raddr = addr_of(5'(rd_r), 5'(rd_c));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state_q)
      S_IDLE: begin
        ram_we    = acc_cmd && (cmd_e'(req.cmd) == CMD_WRITE) && idx_ok;
        ram_waddr = addr_of(5'(req.row_index), 5'(req.column_index));
        ram_wdata = req.element_value;
      end
      S_ROT_P3: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(5'(r_q), 5'(pi_q));
        ram_wdata = round_q28(acc_q);
      end
      S_ROT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(5'(r_q), 5'(pj_q));
        ram_wdata = round_q28(acc_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      S_ROT_P0: begin
        op_a = MulW'(c_q);
        op_b = MulW'(a_q);
      end
      S_ROT_P1: begin
        op_a = MulW'(s_q);
        op_b = MulW'(b_q);
      end
      S_ROT_P2: begin
        op_a = MulW'(s_q);
        op_b = MulW'(a_q);
      end
      S_ROT_P3: begin
        op_a = MulW'(c_q);
        op_b = MulW'(b_q);
      end
      S_DR_P0: begin
        op_a = MulW'(a_q);
        op_b = MulW'(mem_val);
      end
      S_DR_SQ: begin
        op_a = MulW'(d_q);
        op_b = MulW'(d_q);
      end
      default: ;
    endcase
  end

  grme_ram #(.Width(ElemW), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  grme_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_go),
    .angle_i (req.rotation_angle),
    .res_o   (cres)
  );

  grme_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DR_ROOT_GO),
    .radicand_i (sum_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      order_q      <= 4'd8;
      vld_q        <= '0;
      r_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      k_q          <= '0;
      out_read_q   <= '0;
      out_drift_q  <= '0;
      out_status_q <= ST_OK;
      out_batch_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (acc_cmd) begin
            out_read_q   <= '0;
            out_drift_q  <= '0;
            out_status_q <= ST_OK;
            out_batch_q  <= 1'b0;
            case (cmd_e'(req.cmd))
              CMD_WRITE: begin
                if (!idx_ok) out_status_q <= ST_INDEX;
                state_q <= S_RESP;
              end
              CMD_READ: begin
                if (!idx_ok) begin
                  out_status_q <= ST_INDEX;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_RD_REQ;
                end
              end
              CMD_ROTATE: begin
                out_batch_q <= req.last_in_batch;
                if (!plane_ok) begin
                  out_status_q <= ST_PLANE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_ROT_CORDIC;
                end
              end
              CMD_DRIFT: begin
                i_q <= '0;
                j_q <= '0;
                k_q <= '0;
                state_q <= (n == '0) ? S_RESP : S_DR_RDI;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_RD_REQ:  state_q <= S_RD_DATA;
        S_RD_DATA: begin
          out_read_q <= mem_val;
          state_q    <= S_RESP;
        end
        S_ROT_CORDIC: begin
          if (cres.done) begin
            r_q     <= '0;
            state_q <= S_ROT_RDA;
          end
        end
        S_ROT_RDA: state_q <= S_ROT_RDB;
        S_ROT_RDB: state_q <= S_ROT_P0;
        S_ROT_P0:  state_q <= S_ROT_P1;
        S_ROT_P1:  state_q <= S_ROT_P2;
        S_ROT_P2:  state_q <= S_ROT_P3;
        S_ROT_P3:  state_q <= S_ROT_P4;
        S_ROT_P4:  state_q <= S_ROT_WB;
        S_ROT_WB: begin
          if (r_q + 1'b1 == n) begin
            state_q <= S_RESP;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= S_ROT_RDA;
          end
        end
        S_DR_RDI: state_q <= S_DR_RDJ;
        S_DR_RDJ: state_q <= S_DR_P0;
        S_DR_P0:  state_q <= S_DR_ACC;
        S_DR_ACC: begin
          if (k_q + 1'b1 == n) begin
            k_q     <= '0;
            state_q <= S_DR_RND;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_DR_RDI;
          end
        end
        S_DR_RND: state_q <= S_DR_SQ;
        S_DR_SQ:  state_q <= S_DR_SUM;
        S_DR_SUM: begin
          if (j_q + 1'b1 == n) begin
            j_q <= '0;
            if (i_q + 1'b1 == n) begin
              state_q <= S_DR_ROOT_GO;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_DR_RDI;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_DR_RDI;
          end
        end
        S_DR_ROOT_GO: state_q <= S_DR_ROOT;
        S_DR_ROOT: begin
          if (root_done) begin
            out_drift_q <= (root > RootW'(DriftMax)) ? DriftMax : root[DriftW-1:0];
            state_q     <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    prod_q    <= op_a * op_b;
    rd_vld_q  <= vld_q[ram_raddr];
    rd_diag_q <= (rd_r == rd_c);
    if (state_q == S_IDLE) begin
      row_q <= req.row_index;
      col_q <= req.column_index;
      pi_q  <= req.plane_first;
      pj_q  <= req.plane_second;
      sum_q <= '0;
      acc_q <= '0;
    end
    if (cres.done) begin
      c_q <= cres.cos_v;
      s_q <= cres.sin_v;
    end
    case (state_q)
      S_ROT_RDB: a_q <= mem_val;
      S_ROT_P0:  b_q <= mem_val;
      S_ROT_P1:  acc_q <= DotW'(prod_q);
      S_ROT_P2:  acc_q <= acc_q - DotW'(prod_q);
      S_ROT_P3:  acc_q <= DotW'(prod_q);
      S_ROT_P4:  acc_q <= acc_q + DotW'(prod_q);
      S_DR_RDJ:  a_q <= mem_val;
      S_DR_ACC:  acc_q <= acc_q + DotW'(prod_q);
      S_DR_RND: begin
        d_q   <= DiffW'((acc_q - ((i_q == j_q) ? (DotW'(1) <<< 28) : DotW'(0))
                         + DotW'(8192)) >>> 14);
        acc_q <= '0;
      end
      S_DR_SUM:  sum_q <= sum_q + SumW'(prod_q);
      default: ;
    endcase
  end
endmodule

>>> design/grme_ram.sv
module grme_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/grme_cordic.sv
module grme_cordic import grme_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       angle_i,
  output cordic_res_t       res_o
);
  localparam int KW = $clog2(CordicSteps);
  localparam logic signed [ZW-1:0] Quarter = 34'sd1073741824;
  localparam logic signed [ZW-1:0] Half    = 34'sd2147483648;
  localparam logic signed [ZW-1:0] Gain    = 34'sd652032875;

  logic signed [ZW-1:0] x_q, y_q, z_q, z0, xs, ys, xr, yr;
  logic [KW-1:0]        k_q;
  logic                 run_q, flip_q, done_q;
  logic signed [15:0]   xc, yc;

  assign z0 = {{2{angle_i[15]}}, angle_i, 16'h0000};
  assign xs = x_q >>> k_q;
  assign ys = y_q >>> k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
      flip_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        k_q   <= '0;
        x_q   <= Gain;
        y_q   <= '0;
        // fold angles beyond a quarter turn and negate at the end
        if (z0 > Quarter) begin
          z_q    <= z0 - Half;
          flip_q <= 1'b1;
        end else if (z0 < -Quarter) begin
          z_q    <= z0 + Half;
          flip_q <= 1'b1;
        end else begin
          z_q    <= z0;
          flip_q <= 1'b0;
        end
      end else if (run_q) begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_of(5'(k_q));
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_of(5'(k_q));
        end
        if (k_q == KW'(CordicSteps - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
  end

  assign xr = (x_q + ZW'(32768)) >>> 16;
  assign yr = (y_q + ZW'(32768)) >>> 16;

  always_comb begin
    xc = (xr > ZW'(16384)) ? 16'sd16384 : ((xr < -ZW'(16384)) ? -16'sd16384 : xr[15:0]);
    yc = (yr > ZW'(16384)) ? 16'sd16384 : ((yr < -ZW'(16384)) ? -16'sd16384 : yr[15:0]);
  end

  assign res_o.done  = done_q;
  assign res_o.cos_v = flip_q ? -xc : xc;
  assign res_o.sin_v = flip_q ? -yc : yc;
endmodule

>>> design/grme_isqrt.sv
module grme_isqrt import grme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SumW-1:0]  radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);
  localparam int RemW = RootW + 3;
  localparam int CW   = $clog2(RootW);

  logic [SumW-1:0]  rad_q;
  logic [RemW-1:0]  rem_q, t, trial;
  logic [RootW-1:0] root_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;

  assign t     = {rem_q[RemW-3:0], rad_q[SumW-1:SumW-2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (run_q) begin
        // one result bit per cycle, two radicand bits in
        rad_q <= {rad_q[SumW-3:0], 2'b00};
        if (t >= trial) begin
          rem_q  <= t - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= t;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
        if (cnt_q == CW'(RootW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

>>> design/grme_checker.sv
`include "givens_rotation_matrix_engine_macros.svh"

module grme_checker import grme_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] read_value_i,
  input logic [23:0] drift_value_i,
  input logic [1:0]  status_i
);
  `GRME_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `GRME_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "request taken while busy")
  `GRME_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i, "ready while result pending")
  `GRME_ASSERT_IMP(a_plane_zero, clk_i, rst_ni, out_valid_i && (status_i == ST_PLANE), (read_value_i == '0) && (drift_value_i == '0), "ignored rotate carries data")
endmodule

bind givens_rotation_matrix_engine grme_checker u_grme_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req.valid),
  .in_ready_i    (req.ready),
  .out_valid_i   (rsp.valid),
  .out_ready_i   (rsp.ready),
  .read_value_i  (rsp.read_value),
  .drift_value_i (rsp.drift_value),
  .status_i      (rsp.status)
);
